// ===== design/slact_pkg.sv =====
// Shared types, constants and the sigmoid table for the segmentation logit activation.
// Used by slact_operand, slact_interp and segmentation_logit_activation_top.
package slact_pkg;

	localparam int TABLE_ENTRIES = 256;
	localparam int HALF_ENTRIES = TABLE_ENTRIES / 2;
	localparam int LOGIT_W = 16;
	localparam int OP_W = LOGIT_W + 1;             // full-precision logit difference
	localparam int MASK_W = 24;
	localparam int FRAC_W = 11;                    // 2048 = 8.0 in Q8.8
	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int P_W = FRAC_W + IDX_W + 1;
	localparam int TAB_W = 16;
	localparam int PROD_W = TAB_W + FRAC_W;
	localparam int PROB_W = 17;                    // 0 .. 65536
	localparam logic [PROB_W-1:0] PROB_ONE = PROB_W'(65536);

	// register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CLASS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd2;
	localparam int CFG_DATA_W = 2;

	// activation modes
	localparam logic [1:0] MODE_NONE = 2'd0;
	localparam logic [1:0] MODE_SIGMOID = 2'd1;
	localparam logic [1:0] MODE_SOFTMAX = 2'd2;
	localparam logic [1:0] TWO_CHANNELS = 2'd2;

	typedef enum logic [1:0] {
		KIND_PASS,
		KIND_SIG,
		KIND_ZERO
	} kind_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       chosen;
		logic [1:0] count;
	} cfg_t;

	// what the output stage needs besides the probability
	typedef struct packed {
		kind_t                     kind;
		logic                      err;
		logic signed [LOGIT_W-1:0] logit;
	} side_t;

	typedef struct packed {
		logic              neg;
		logic              sat;
		logic [IDX_W-1:0]  idx;
		logic [FRAC_W-1:0] frac;
	} sig_op_t;

	typedef struct packed {
		logic              neg;
		logic              sat;
		logic [PROB_W-1:0] v;
	} sig_res_t;

	// each entry holds {T[k], T[k+1] - T[k]} so one read serves the interpolation
	typedef logic [2*TAB_W-1:0] rom_t [TABLE_ENTRIES];

	// shift-subtract quotient, used only while the table is built at elaboration
	function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] dvs);
		logic [63:0] q;
		logic [63:0] r;
		q = '0;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[62:0], num[b]};
			if (r >= dvs) begin
				r = r - dvs;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// T[k] ~ 65536 * sigmoid(8k/N); exp(-8/N) by Taylor series, powers by repeated product
	function automatic rom_t build_rom();
		logic [63:0] t;
		logic [63:0] term;
		logic [63:0] pos;
		logic [63:0] neg;
		logic [63:0] base;
		logic [63:0] e;
		logic [63:0] den;
		logic [TAB_W-1:0] tv [TABLE_ENTRIES+1];
		rom_t r;
		t = udiv((64'd8 << 30) + 64'(HALF_ENTRIES), 64'(TABLE_ENTRIES));
		term = 64'd1 << 30;
		pos = term;
		neg = 64'd0;
		for (int n = 1; n <= 16; n++) begin
			term = (term * t + (64'd1 << 29)) >> 30;
			term = udiv(term + 64'(n >> 1), 64'(n));
			if (n % 2 == 1) neg = neg + term;
			else pos = pos + term;
		end
		base = (pos > neg) ? pos - neg : 64'd0;
		e = 64'd1 << 30;
		for (int k = 0; k <= TABLE_ENTRIES; k++) begin
			den = (64'd1 << 30) + e;
			tv[k] = TAB_W'(udiv((64'd1 << 46) + (den >> 1), den));
			e = (e * base + (64'd1 << 29)) >> 30;
		end
		for (int k = 0; k < TABLE_ENTRIES; k++) begin
			r[k] = {tv[k], (tv[k+1] > tv[k]) ? TAB_W'(tv[k+1] - tv[k]) : TAB_W'(0)};
		end
		return r;
	endfunction

	localparam rom_t SIG_ROM = build_rom();

endpackage

// ===== design/slact_operand.sv =====
// Stages 1 and 2: operand select from the mode registers, then magnitude,
// saturation and table index/fraction. Depends on slact_pkg.
module slact_operand (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  slact_pkg::cfg_t                       cfg,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [slact_pkg::LOGIT_W-1:0]  logit_zero,
	input  logic signed [slact_pkg::LOGIT_W-1:0]  logit_one,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output slact_pkg::sig_op_t                    out_op,
	output slact_pkg::side_t                      out_side
);

	logic rdy_s1, rdy_s2;
	logic vld_s1, vld_s2;
	logic signed [slact_pkg::OP_W-1:0] x_d, x_s1;
	logic signed [slact_pkg::OP_W-1:0] l0e, l1e;
	slact_pkg::side_t side_d, side_s1, side_s2;
	slact_pkg::sig_op_t op_d, op_s2;
	logic [slact_pkg::OP_W-1:0] mag;
	logic [slact_pkg::P_W-1:0] p;

	assign rdy_s2 = !vld_s2 || out_ready;
	assign rdy_s1 = !vld_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	// stage 1: pick the sigmoid argument
	always_comb begin
		l0e = slact_pkg::OP_W'(logit_zero);
		l1e = slact_pkg::OP_W'(logit_one);
		x_d = l0e;
		side_d.logit = logit_zero;
		side_d.err = 1'b0;
		side_d.kind = slact_pkg::KIND_ZERO;
		unique case (cfg.mode)
			slact_pkg::MODE_NONE: begin
				side_d.kind = slact_pkg::KIND_PASS;
			end
			slact_pkg::MODE_SIGMOID: begin
				side_d.kind = slact_pkg::KIND_SIG;
			end
			slact_pkg::MODE_SOFTMAX: begin
				if (cfg.count == slact_pkg::TWO_CHANNELS) begin
					side_d.kind = slact_pkg::KIND_SIG;
					x_d = cfg.chosen ? (l1e - l0e) : (l0e - l1e);
				end else begin
					side_d.err = 1'b1;
				end
			end
			default: begin
				side_d.kind = slact_pkg::KIND_ZERO;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rdy_s1) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			x_s1 <= x_d;
			side_s1 <= side_d;
		end
	end

	// stage 2: |x| >= 8.0 saturates; otherwise split |x|*N/2048 into index and fraction
	always_comb begin
		op_d.neg = x_s1[slact_pkg::OP_W-1];
		mag = op_d.neg ? (~x_s1 + slact_pkg::OP_W'(1)) : x_s1;
		op_d.sat = |mag[slact_pkg::OP_W-1:slact_pkg::FRAC_W];
		p = slact_pkg::P_W'(mag[slact_pkg::FRAC_W-1:0])
			* slact_pkg::P_W'(slact_pkg::TABLE_ENTRIES);
		op_d.idx = p[slact_pkg::FRAC_W +: slact_pkg::IDX_W];
		op_d.frac = p[slact_pkg::FRAC_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (rdy_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && vld_s1) begin
			op_s2 <= op_d;
			side_s2 <= side_s1;
		end
	end

	assign out_valid = vld_s2;
	assign out_op = op_s2;
	assign out_side = side_s2;

endmodule

// ===== design/slact_interp.sv =====
// Stages 3 and 4: sigmoid table read, then linear interpolation with
// round-half-up. Depends on slact_pkg (SIG_ROM and types).
module slact_interp (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  slact_pkg::sig_op_t       in_op,
	input  slact_pkg::side_t         in_side,
	output logic                     out_valid,
	input  logic                     out_ready,
	output slact_pkg::sig_res_t      out_res,
	output slact_pkg::side_t         out_side
);

	logic rdy_s3, rdy_s4;
	logic vld_s3, vld_s4;
	logic [2*slact_pkg::TAB_W-1:0] ent;
	logic [slact_pkg::TAB_W-1:0] lo_s3, d_s3;
	logic [slact_pkg::FRAC_W-1:0] frac_s3;
	logic neg_s3, sat_s3;
	slact_pkg::side_t side_s3, side_s4;
	logic [slact_pkg::PROD_W:0] rnd;
	slact_pkg::sig_res_t res_d, res_s4;

	assign rdy_s4 = !vld_s4 || out_ready;
	assign rdy_s3 = !vld_s3 || rdy_s4;
	assign in_ready = rdy_s3;

	assign ent = slact_pkg::SIG_ROM[in_op.idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (rdy_s3) begin
			vld_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && in_valid) begin
			lo_s3 <= ent[2*slact_pkg::TAB_W-1:slact_pkg::TAB_W];
			d_s3 <= ent[slact_pkg::TAB_W-1:0];
			frac_s3 <= in_op.frac;
			neg_s3 <= in_op.neg;
			sat_s3 <= in_op.sat;
			side_s3 <= in_side;
		end
	end

	always_comb begin
		rnd = (slact_pkg::PROD_W+1)'(slact_pkg::PROD_W'(d_s3) * slact_pkg::PROD_W'(frac_s3))
			+ (slact_pkg::PROD_W+1)'(1 << (slact_pkg::FRAC_W - 1));
		res_d.v = slact_pkg::PROB_W'(lo_s3)
			+ slact_pkg::PROB_W'(rnd >> slact_pkg::FRAC_W);
		res_d.neg = neg_s3;
		res_d.sat = sat_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (rdy_s4) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4 && vld_s3) begin
			res_s4 <= res_d;
			side_s4 <= side_s3;
		end
	end

	assign out_valid = vld_s4;
	assign out_res = res_s4;
	assign out_side = side_s4;

endmodule

// ===== design/segmentation_logit_activation_top.sv =====
// Top level: configuration registers, operand and interpolation pipeline, output stage.
// Depends on slact_pkg, slact_operand and slact_interp.
//
// Usage:
//   s_* stream carries one pixel per item: two signed Q8.8 logits.
//   m_* stream returns one item per pixel: a signed Q8.16 mask value in tdata
//   and the mode error flag in tuser.
//   The cfg_* port writes activation_mode (0), chosen_class (1) and
//   channel_count (2); write only while no item is in flight.
// Timing:
//   Five register stages (operand select, index split, table read, interpolate,
//   output). One item per cycle sustained while m_tready stays high: the table lookup
//   and the 16x11 interpolation multiply each take one stage.
// Reset:
//   arst_n empties every stage and sets mode none, class 0, one channel.
//   The sigmoid table is constant logic and needs no fill.
// Backpressure:
//   Each stage holds its item while the next is full; s_tready stays high
//   while any stage, the output register included, has a free slot.
module segmentation_logit_activation_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [31:0]                         s_tdata,   // logit_zero[15:0], logit_one[31:16]
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [23:0]                         m_tdata,   // mask[23:0]
	output logic [0:0]                          m_tuser,   // mode_error[0]
	input  logic                                cfg_we,
	input  logic [slact_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [slact_pkg::CFG_DATA_W-1:0]    cfg_data
);

	slact_pkg::cfg_t cfg_q;
	logic op_valid, op_ready;
	slact_pkg::sig_op_t op;
	slact_pkg::side_t op_side;
	logic ip_valid, ip_ready;
	slact_pkg::sig_res_t ip_res;
	slact_pkg::side_t ip_side;
	logic rdy_s5;
	logic [slact_pkg::PROB_W-1:0] prob, res;
	logic [slact_pkg::MASK_W-1:0] mask_d, mask_s5;
	logic err_s5;
	slact_pkg::kind_t kind_s5;
	logic vld_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode <= slact_pkg::MODE_NONE;
			cfg_q.chosen <= 1'b0;
			cfg_q.count <= 2'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				slact_pkg::CFG_MODE: cfg_q.mode <= cfg_data;
				slact_pkg::CFG_CLASS: cfg_q.chosen <= cfg_data[0];
				slact_pkg::CFG_COUNT: cfg_q.count <= cfg_data;
				default: ;
			endcase
		end
	end

	slact_operand u_operand (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.logit_zero(s_tdata[15:0]),
		.logit_one(s_tdata[31:16]),
		.out_valid(op_valid),
		.out_ready(op_ready),
		.out_op(op),
		.out_side(op_side)
	);

	slact_interp u_interp (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(op_valid),
		.in_ready(op_ready),
		.in_op(op),
		.in_side(op_side),
		.out_valid(ip_valid),
		.out_ready(ip_ready),
		.out_res(ip_res),
		.out_side(ip_side)
	);

	assign rdy_s5 = !vld_s5 || m_tready;
	assign ip_ready = rdy_s5;

	// saturation, sign fold and mode select
	always_comb begin
		prob = ip_res.sat ? slact_pkg::PROB_ONE : ip_res.v;
		res = ip_res.neg ? (slact_pkg::PROB_ONE - prob) : prob;
		unique case (ip_side.kind)
			slact_pkg::KIND_PASS: mask_d = {ip_side.logit, 8'd0};
			slact_pkg::KIND_SIG: mask_d = slact_pkg::MASK_W'(res);
			default: mask_d = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (rdy_s5) begin
			vld_s5 <= ip_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s5 && ip_valid) begin
			mask_s5 <= mask_d;
			err_s5 <= ip_side.err;
			kind_s5 <= ip_side.kind;
		end
	end

	assign m_tvalid = vld_s5;
	assign m_tdata = mask_s5;
	assign m_tuser = err_s5;

	// an error item carries a zero mask
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata == '0)
		else $error("mode error item with nonzero mask");

	// probabilities never exceed 1.0 (65536)
	a_prob_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && kind_s5 == slact_pkg::KIND_SIG |->
			m_tdata[23:17] == '0 && (!m_tdata[16] || m_tdata[15:0] == '0))
		else $error("probability out of range");

	// input stalls only when every stage is full and the sink holds off
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready && ip_valid && op_valid)
		else $error("input stalled with a free stage");

endmodule
